### sv/pwt_pkg.sv
`default_nettype none
package pwt_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 11;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SUM3_W     = PIX_W + 2;
  localparam int GRAD_W     = PIX_W + 3;
  localparam int SQ_W       = 2 * (GRAD_W - 1);
  localparam int SUM_W      = SQ_W + 1;
  localparam int LIM_W      = 2 * PIX_W + 1;

  localparam logic [SIZE_W-1:0] MIN_SIZE   = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] MAX_W_SIZE = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_H_SIZE = SIZE_W'(MAX_HEIGHT);

  localparam logic [PIX_W-1:0]  THR_RESET  = PIX_W'(128);
  localparam logic [PIX_W-1:0]  THR_MAX    = PIX_W'(255);

  localparam logic [1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             start_of_frame;
  } pwt_in_t;

  typedef struct packed {
    logic edge_res;
    logic last_of_frame;
  } pwt_out_t;

  // control that rides along with each pixel through the pipe
  typedef struct packed {
    logic valid;
    logic produce;
    logic last;
  } pwt_ctl_t;

  // one new window column: row r-2, row r-1, row r
  typedef struct packed {
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] px;
  } pwt_col_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] res;
    begin
      if (v < MIN_SIZE) begin
        res = MIN_SIZE;
      end else if (v > hi) begin
        res = hi;
      end else begin
        res = v;
      end
      return res;
    end
  endfunction

endpackage
`default_nettype wire

### sv/pwt_linebuf.sv
`default_nettype none
module pwt_linebuf
  import pwt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_fire,
  input  wire pwt_in_t           in_data,
  input  wire logic [SIZE_W-1:0] frame_width,
  input  wire logic [SIZE_W-1:0] frame_height,
  output pwt_col_t               col_o,
  output pwt_ctl_t               ctl_o
);

  logic [2*PIX_W-1:0] lb_mem [MAX_WIDTH];

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   c_cur;
  logic [ROW_W-1:0]   r_cur;
  logic [SIZE_W-1:0]  wm1, hm1;
  logic               end_row, end_frame, produce;

  logic [2*PIX_W-1:0] rd_q_r;
  logic               fwd_r;
  logic [2*PIX_W-1:0] fwd_data_r;
  logic [2*PIX_W-1:0] rd_data;
  logic [2*PIX_W-1:0] wr_data;
  pwt_ctl_t           s1_ctl_r;
  logic [PIX_W-1:0]   s1_px_r;
  logic [COL_W-1:0]   s1_addr_r;

  always_comb begin
    wm1       = clamp_size(frame_width, MAX_W_SIZE) - SIZE_W'(1);
    hm1       = clamp_size(frame_height, MAX_H_SIZE) - SIZE_W'(1);
    c_cur     = in_data.start_of_frame ? '0 : col_r;
    r_cur     = in_data.start_of_frame ? '0 : row_r;
    end_row   = SIZE_W'(c_cur) >= wm1;
    end_frame = end_row && (SIZE_W'(r_cur) >= hm1);
    produce   = (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
    if (end_row) begin
      col_nxt = '0;
      row_nxt = end_frame ? '0 : r_cur + ROW_W'(1);
    end else begin
      col_nxt = c_cur + COL_W'(1);
      row_nxt = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // the entry written back by stage 1 at the same edge reads stale: forward it
  assign rd_data = fwd_r ? fwd_data_r : rd_q_r;
  assign wr_data = {rd_data[PIX_W-1:0], s1_px_r};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_q_r <= lb_mem[c_cur];
    end
    if (en && s1_ctl_r.valid) begin
      lb_mem[s1_addr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      fwd_r    <= 1'b0;
    end else if (en) begin
      s1_ctl_r.valid   <= in_fire;
      s1_ctl_r.produce <= produce;
      s1_ctl_r.last    <= end_frame;
      if (in_fire) begin
        fwd_r <= s1_ctl_r.valid && (s1_addr_r == c_cur);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r    <= in_data.pixel;
      s1_addr_r  <= c_cur;
      fwd_data_r <= wr_data;
    end
  end

  assign col_o.up  = rd_data[2*PIX_W-1:PIX_W];
  assign col_o.mid = rd_data[PIX_W-1:0];
  assign col_o.px  = s1_px_r;
  assign ctl_o     = s1_ctl_r;

endmodule
`default_nettype wire

### sv/pwt_window.sv
`default_nettype none
module pwt_window
  import pwt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire pwt_col_t                 col_i,
  input  wire pwt_ctl_t                 ctl_i,
  output logic signed [GRAD_W-1:0]      gv_o,
  output logic signed [GRAD_W-1:0]      gh_o,
  output pwt_ctl_t                      ctl_o
);

  logic [PIX_W-1:0]  win_r [9];
  pwt_ctl_t          s2_ctl_r, s3_ctl_r;
  logic [SUM3_W-1:0] top_sum, bot_sum, left_sum, right_sum;
  logic signed [GRAD_W-1:0] gv_r, gh_r;

  // shift left one column, new column enters on the right
  always_ff @(posedge clk) begin
    if (en && ctl_i.valid) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[2] <= col_i.up;
      win_r[5] <= col_i.mid;
      win_r[8] <= col_i.px;
    end
  end

  always_comb begin
    top_sum   = SUM3_W'(win_r[0]) + SUM3_W'(win_r[1]) + SUM3_W'(win_r[2]);
    bot_sum   = SUM3_W'(win_r[6]) + SUM3_W'(win_r[7]) + SUM3_W'(win_r[8]);
    left_sum  = SUM3_W'(win_r[0]) + SUM3_W'(win_r[3]) + SUM3_W'(win_r[6]);
    right_sum = SUM3_W'(win_r[2]) + SUM3_W'(win_r[5]) + SUM3_W'(win_r[8]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gv_r <= $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});
      gh_r <= $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
    end else if (en) begin
      s2_ctl_r <= ctl_i;
      s3_ctl_r <= s2_ctl_r;
    end
  end

  assign gv_o  = gv_r;
  assign gh_o  = gh_r;
  assign ctl_o = s3_ctl_r;

endmodule
`default_nettype wire

### sv/pwt_mag.sv
`default_nettype none
module pwt_mag
  import pwt_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic signed [GRAD_W-1:0] gv_i,
  input  wire logic signed [GRAD_W-1:0] gh_i,
  input  wire pwt_ctl_t                ctl_i,
  input  wire logic [PIX_W-1:0]        threshold,
  output logic                         res_valid_o,
  output pwt_out_t                     res_o
);

  logic signed [2*GRAD_W-1:0] sqv_full, sqh_full;
  logic [SQ_W-1:0]  sqv_r, sqh_r;
  logic [LIM_W-1:0] lim_r;
  logic [SUM_W-1:0] mag_sq;
  pwt_ctl_t         s4_ctl_r;

  assign sqv_full = gv_i * gv_i;
  assign sqh_full = gh_i * gh_i;

  always_ff @(posedge clk) begin
    if (en) begin
      sqv_r <= sqv_full[SQ_W-1:0];
      sqh_r <= sqh_full[SQ_W-1:0];
    end
    // magnitude > threshold, tested on the squares
    lim_r <= LIM_W'((PIX_W+1)'(threshold) + (PIX_W+1)'(1))
           * LIM_W'((PIX_W+1)'(threshold) + (PIX_W+1)'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_ctl_r <= '0;
    end else if (en) begin
      s4_ctl_r <= ctl_i;
    end
  end

  assign mag_sq              = SUM_W'(sqv_r) + SUM_W'(sqh_r);
  assign res_valid_o         = s4_ctl_r.valid && s4_ctl_r.produce;
  assign res_o.edge_res      = (threshold != THR_MAX) && (mag_sq >= SUM_W'(lim_r));
  assign res_o.last_of_frame = s4_ctl_r.last;

endmodule
`default_nettype wire

### sv/prewitt_edge_threshold_top.sv
`default_nettype none
// Prewitt 3x3 edge detector with threshold. Pixels enter in raster order, one
// per clock; a single 1024x16 line memory (rows r-2 and r-1 side by side) is
// read at the current column and written back from the stage-1 registers,
// with forwarding when the same column comes round again at once. One result
// bit per interior pixel passes the stage-1, window, gradient and square
// registers into the output register; border pixels give no beat. The
// sustained rate is one pixel per clock, limited by the single line memory
// port pair. An output register and a one-beat skid keep input taken while
// a result waits; input stalls only while the skid is full. Registers (APB,
// byte address 4*i): 0 threshold, 1 frame_width, 2 frame_height; sizes clamp
// to 3..1024. Write them only while the pipe is empty.
module prewitt_edge_threshold_top
  import pwt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire pwt_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output pwt_out_t         out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [PIX_W-1:0]  thr_r;
  logic [SIZE_W-1:0] fw_r, fh_r;
  logic              cfg_wr;

  logic              en, in_fire, take;
  pwt_col_t          col1;
  pwt_ctl_t          ctl1, ctl3;
  logic signed [GRAD_W-1:0] gv3, gh3;
  logic              res_valid;
  pwt_out_t          res;

  logic              out_valid_r, skid_valid_r;
  pwt_out_t          out_data_r, skid_data_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      fw_r  <= MAX_W_SIZE;
      fh_r  <= MAX_H_SIZE;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_THRESHOLD:    thr_r <= pwdata[PIX_W-1:0];
        REG_FRAME_WIDTH:  fw_r  <= pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT: fh_r  <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_THRESHOLD:    prdata = 32'(thr_r);
      REG_FRAME_WIDTH:  prdata = 32'(fw_r);
      REG_FRAME_HEIGHT: prdata = 32'(fh_r);
      default:          prdata = '0;
    endcase
  end

  // pipe advances unless the skid holds a beat
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !in_stall;
  assign take     = out_valid_r && !out_stall;

  pwt_linebuf u_linebuf (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_fire      (in_fire),
    .in_data      (in_data),
    .frame_width  (fw_r),
    .frame_height (fh_r),
    .col_o        (col1),
    .ctl_o        (ctl1)
  );

  pwt_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .col_i (col1),
    .ctl_i (ctl1),
    .gv_o  (gv3),
    .gh_o  (gh3),
    .ctl_o (ctl3)
  );

  pwt_mag u_mag (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .gv_i        (gv3),
    .gh_i        (gh3),
    .ctl_i       (ctl3),
    .threshold   (thr_r),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_data_r <= skid_data_r;
      end
    end else if (res_valid) begin
      if (!out_valid_r || take) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled without a stalled output beat");

  a_skid_drain_keeps_out: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> (out_valid_r && !skid_valid_r))
    else $error("skid beat lost on drain");

endmodule
`default_nettype wire

### verif/edge_stream_checker.sv
`timescale 1ns / 1ps
module edge_stream_checker
  import pwt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire pwt_in_t     in_data,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire pwt_out_t    out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               error_count,
  output int               expect_pending
);

  logic [PIX_W-1:0]  cfg_thr;
  logic [SIZE_W-1:0] cfg_width;
  logic [SIZE_W-1:0] cfg_height;

  logic [PIX_W-1:0] row_older [MAX_WIDTH];
  logic [PIX_W-1:0] row_prev  [MAX_WIDTH];
  logic [PIX_W-1:0] win [9];
  int col_pos;
  int row_pos;

  pwt_out_t edge_expect_q[$];
  int error_total = 0;
  int result_index = 0;

  assign error_count    = error_total;
  assign expect_pending = edge_expect_q.size();

  task automatic flag_error(input string what);
    if (error_total < 10) $display("%0t: %s", $time, what);
    error_total++;
  endtask

  // Advance the window by one pixel and queue the edge bit it yields, if any.
  task automatic take_pixel(input pwt_in_t beat);
    int w_eff;
    int h_eff;
    int c;
    int r;
    int gv;
    int gh;
    int lim;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    bit end_row;
    bit end_frame;
    pwt_out_t want;
    w_eff = (cfg_width < 3) ? 3 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width));
    h_eff = (cfg_height < 3) ? 3 : ((cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_height));
    if (beat.start_of_frame) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
    r = row_pos;
    up = row_older[c];
    mid = row_prev[c];
    row_older[c] = mid;
    row_prev[c] = beat.pixel;
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = beat.pixel;
    end_row = (c >= w_eff - 1);
    end_frame = end_row && (r >= h_eff - 1);
    if (r >= 2 && c >= 2) begin
      gv = (win[6] + win[7] + win[8]) - (win[0] + win[1] + win[2]);
      gh = (win[2] + win[5] + win[8]) - (win[0] + win[3] + win[6]);
      lim = (cfg_thr + 1) * (cfg_thr + 1);
      want.edge_res = (cfg_thr != THR_MAX) && (gv * gv + gh * gh >= lim);
      want.last_of_frame = end_frame;
      edge_expect_q.push_back(want);
    end
    if (end_row) begin
      col_pos = 0;
      row_pos = end_frame ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  always @(posedge clk) begin
    pwt_out_t want;
    if (!rst_n) begin
      cfg_thr = THR_RESET;
      cfg_width = MAX_W_SIZE;
      cfg_height = MAX_H_SIZE;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_older[i] = '0;
        row_prev[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      edge_expect_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_THRESHOLD:    cfg_thr = pwdata[PIX_W-1:0];
          REG_FRAME_WIDTH:  cfg_width = pwdata[SIZE_W-1:0];
          REG_FRAME_HEIGHT: cfg_height = pwdata[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (edge_expect_q.size() == 0) begin
          flag_error($sformatf("unexpected result beat %0d: edge_res %0b last_of_frame %0b",
                               result_index, out_data.edge_res, out_data.last_of_frame));
        end else begin
          want = edge_expect_q.pop_front();
          if (out_data.edge_res !== want.edge_res)
            flag_error($sformatf("result %0d edge_res: expected %0b, actual %0b",
                                 result_index, want.edge_res, out_data.edge_res));
          if (out_data.last_of_frame !== want.last_of_frame)
            flag_error($sformatf("result %0d last_of_frame: expected %0b, actual %0b",
                                 result_index, want.last_of_frame, out_data.last_of_frame));
        end
        result_index++;
      end
      if (in_valid && !in_stall) take_pixel(in_data);
    end
  end

endmodule

### verif/prewitt_edge_threshold_top_test.sv
`timescale 1ns / 1ps
module prewitt_edge_threshold_top_test
  import pwt_pkg::*;
();

  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  pwt_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  pwt_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int error_count;
  int expect_pending;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_armed = 0;
  bit hold_done = 0;

  // raster position as the sender sees it, used only to place frame starts
  int frame_w = MAX_WIDTH;
  int frame_h = MAX_HEIGHT;
  int pos_col = 0;
  int pos_row = 0;

  prewitt_edge_threshold_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  edge_stream_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .error_count   (error_count),
    .expect_pending(expect_pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random stall, plus one long hold-off once armed
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(3))
      0, 1:    return PIX_W'($urandom_range(255));
      2:       return {PIX_W{1'($urandom_range(1))}};
      default: return PIX_W'(120 + $urandom_range(15));
    endcase
  endfunction

  // call at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(input pwt_in_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_px(input logic [PIX_W-1:0] px, input bit sof);
    pwt_in_t beat;
    beat.pixel = px;
    beat.start_of_frame = sof;
    if (sof) begin
      pos_col = 0;
      pos_row = 0;
    end
    send_beat(beat);
    if (pos_col >= frame_w - 1) begin
      pos_col = 0;
      pos_row = (pos_row >= frame_h - 1) ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
  endtask

  task automatic stream_pixels(input int count, input bit sof_first, input bit allow_break);
    bit sof;
    for (int n = 0; n < count; n++) begin
      if (n == 0 && sof_first) sof = 1'b1;
      else if (pos_col == 0 && pos_row == 0) sof = ($urandom_range(3) != 0);
      else sof = allow_break && ($urandom_range(199) == 0);
      send_px(pick_pixel(), sof);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // drop valid, let every queued result out, then give the pipe time to empty
  task automatic drain_pipe();
    in_valid = 1'b0;
    while (expect_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apply_setting(input int thr, input int w, input int h);
    drain_pipe();
    write_reg(REG_THRESHOLD, 32'(thr));
    write_reg(REG_FRAME_WIDTH, 32'(w));
    write_reg(REG_FRAME_HEIGHT, 32'(h));
    frame_w = (w < 3) ? 3 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    frame_h = (h < 3) ? 3 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 26;
    recv_idle_pct = 45;

    // gradient of exactly 10 sits on the threshold 9 boundary
    apply_setting(9, 3, 3);
    for (int i = 0; i < 9; i++) send_px((i == 7) ? 8'd10 : 8'd0, i == 0);
    // bright top row, frame begins by wrap-around
    for (int i = 0; i < 9; i++) send_px((i < 3) ? 8'd255 : 8'd0, 1'b0);
    send_px(8'd77, 1'b0);
    send_px(8'd200, 1'b0);
    // same window one step above the boundary; new start cuts the open frame
    apply_setting(10, 3, 3);
    for (int i = 0; i < 9; i++) send_px((i == 7) ? 8'd10 : 8'd0, i == 0);
    apply_setting(THR_MAX, 3, 3);
    for (int i = 0; i < 9; i++) send_px((i % 3 == 2) ? 8'd255 : 8'd0, i == 0);

    apply_setting($urandom_range(255), 5, 1);
    stream_pixels(200, 1'b1, 1'b1);
    apply_setting(0, 0, 2047);
    stream_pixels(120, 1'b1, 1'b1);
    // stop mid-frame, then shrink the frame so the counters sit past the end
    apply_setting(128, 16, 16);
    stream_pixels(90, 1'b1, 1'b0);
    apply_setting($urandom_range(255), 4, 6);
    stream_pixels(120, 1'b0, 1'b1);

    send_idle_pct = 45;
    recv_idle_pct = 26;
    apply_setting(255, 7, 5);
    stream_pixels(150, 1'b1, 1'b1);
    apply_setting($urandom_range(255), $urandom_range(3, 12), $urandom_range(3, 10));
    stream_pixels(300, 1'b1, 1'b1);
    apply_setting($urandom_range(255), 3, 1024);
    stream_pixels(120, 1'b1, 1'b1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_setting($urandom_range(255), 8, 8);
    hold_armed = 1'b1;
    stream_pixels(300, 1'b1, 1'b1);
    apply_setting($urandom_range(255), 100, 3);
    stream_pixels(300, 1'b1, 1'b0);

    drain_pipe();
    if (error_count == 0 && expect_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
